// ===== hw/rtl/mctr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mctr_pkg
// Shared constants and types of the mouse counter to cell tracker.
// ---------------------------------------------------------------------------
package mctr_pkg;

  // Scales are powers of two; the cell index is a plain shift of the position.
  localparam int X_SHIFT = 2;
  localparam int Y_SHIFT = 3;
  localparam int X_SCALE = 1 << X_SHIFT;
  localparam int Y_SCALE = 1 << Y_SHIFT;

  localparam int CNT_W   = 8;
  localparam int COLS_W  = 8;
  localparam int ROWS_W  = 7;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int WHEEL_W = 4;
  localparam int WCHG_W  = 8;

  localparam int COLS_MAX = 128;
  localparam int ROWS_MAX = 64;
  localparam int COLS_RESET = 80;
  localparam int ROWS_RESET = 25;

  localparam int POS_X_W = $clog2((COLS_MAX - 1) * X_SCALE + 1);
  localparam int POS_Y_W = $clog2((ROWS_MAX - 1) * Y_SCALE + 1);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;

  localparam logic [POS_X_W-1:0] POS_X_RESET = POS_X_W'((COLS_RESET / 2) * X_SCALE);
  localparam logic [POS_Y_W-1:0] POS_Y_RESET = POS_Y_W'((ROWS_RESET / 2) * Y_SCALE);

  typedef struct packed {
    logic [CNT_W-1:0]   prev_x;
    logic [CNT_W-1:0]   prev_y;
    logic               prev_left;
    logic [WHEEL_W-1:0] prev_wheel;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic               seen;
  } trk_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] counter_x;
    logic [CNT_W-1:0] counter_y;
    logic [CNT_W-1:0] button_byte;
  } trk_sample_t;

  typedef struct packed {
    logic [COL_W-1:0]  cell_col;
    logic [ROW_W-1:0]  cell_row;
    logic              left_click;
    logic              left_held;
    logic [WCHG_W-1:0] wheel_change;
    logic              moved;
  } trk_result_t;

endpackage

// ===== hw/rtl/mouse_counter_to_cell_tracker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mouse_counter_to_cell_tracker
// Turns polled 8-bit mouse counters and the button byte into a character
// cell position, left-button press edge and level, and wheel change.
// ---------------------------------------------------------------------------
// Each accepted word is one poll sample. It is registered, processed against
// the tracker state and placed in the output register, so the block takes
// one sample per clock while the output is not stalled; a sample's word is
// held in the sample register, and its result word enters the output register
// once that register is free, and a stalled output holds the input back.
// The first sample after reset only records the counters and centres the
// cursor on the screen given by the columns and rows registers. Write the
// registers only while no sample is in flight.
// ---------------------------------------------------------------------------
module mouse_counter_to_cell_tracker
  import mctr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // counter_x[7:0], counter_y[15:8], button_byte[23:16]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cell_col[6:0], cell_row[12:7], left_click[13], left_held[14],
  // wheel_change[22:15], moved[23]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [COLS_W-1:0] columns_r;
  logic [ROWS_W-1:0] rows_r;
  trk_state_t        state_r, state_nxt;
  trk_sample_t       sample_r;
  logic              s1_valid_r;
  trk_result_t       result, result_r;
  logic              out_valid_r;
  logic              advance;

  assign advance   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLS_W'(COLS_RESET);
      rows_r    <= ROWS_W'(ROWS_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: columns_r <= cfg_wdata[COLS_W-1:0];
        REG_ROWS:    rows_r    <= cfg_wdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  mctr_core u_core (
    .state     (state_r),
    .sample    (sample_r),
    .columns   (columns_r),
    .rows      (rows_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{prev_x: '0, prev_y: '0, prev_left: 1'b1, prev_wheel: '0,
                      pos_x: POS_X_RESET, pos_y: POS_Y_RESET, seen: 1'b0};
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // first struct member sits in the top bits
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) sample_r <= trk_sample_t'({in_tdata[7:0], in_tdata[15:8],
                                                           in_tdata[23:16]});
    if (advance) result_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {result_r.moved, result_r.wheel_change, result_r.left_held,
                       result_r.left_click, result_r.cell_row, result_r.cell_col};

endmodule

// ===== hw/rtl/mctr_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mctr_core
// Per-sample datapath: counter deltas, position update and clamp, button
// edge and wheel change. Pure combinational; the caller holds the state.
// ---------------------------------------------------------------------------
module mctr_core
  import mctr_pkg::*;
(
  input  trk_state_t        state,
  input  trk_sample_t       sample,
  input  logic [COLS_W-1:0] columns,
  input  logic [ROWS_W-1:0] rows,
  output trk_state_t        state_nxt,
  output trk_result_t       result
);

  localparam int SX_W = POS_X_W + 2;
  localparam int SY_W = POS_Y_W + 2;

  logic [COLS_W-1:0]  cols_eff;
  logic [ROWS_W-1:0]  rows_eff;
  logic [POS_X_W-1:0] max_x, ctr_x, pos_x;
  logic [POS_Y_W-1:0] max_y, ctr_y, pos_y;
  logic [CNT_W-1:0]   dx, dy;
  logic signed [SX_W-1:0] sum_x;
  logic signed [SY_W-1:0] sum_y;
  logic               left_bit;
  logic [WHEEL_W-1:0] wheel, wdiff;
  logic [POS_X_W-1:0] col_full;
  logic [POS_Y_W-1:0] row_full;

  always_comb begin
    // out-of-range register values saturate
    if (columns == '0) cols_eff = COLS_W'(1);
    else if (columns > COLS_W'(COLS_MAX)) cols_eff = COLS_W'(COLS_MAX);
    else cols_eff = columns;
    if (rows == '0) rows_eff = ROWS_W'(1);
    else if (rows > ROWS_W'(ROWS_MAX)) rows_eff = ROWS_W'(ROWS_MAX);
    else rows_eff = rows;
  end

  assign max_x = POS_X_W'(cols_eff - COLS_W'(1)) << X_SHIFT;
  assign max_y = POS_Y_W'(rows_eff - ROWS_W'(1)) << Y_SHIFT;
  assign ctr_x = POS_X_W'(cols_eff >> 1) << X_SHIFT;
  assign ctr_y = POS_Y_W'(rows_eff >> 1) << Y_SHIFT;

  // wrapped 8-bit deltas; Y is inverted
  assign dx = sample.counter_x - state.prev_x;
  assign dy = state.prev_y - sample.counter_y;

  assign sum_x = $signed({2'b00, state.pos_x}) + $signed({{(SX_W-CNT_W){dx[CNT_W-1]}}, dx});
  assign sum_y = $signed({2'b00, state.pos_y}) + $signed({{(SY_W-CNT_W){dy[CNT_W-1]}}, dy});

  always_comb begin
    if (!state.seen) begin
      pos_x = ctr_x;
    end else if (sum_x < 0) begin
      pos_x = '0;
    end else if (sum_x > $signed({2'b00, max_x})) begin
      pos_x = max_x;
    end else begin
      pos_x = sum_x[POS_X_W-1:0];
    end
    if (!state.seen) begin
      pos_y = ctr_y;
    end else if (sum_y < 0) begin
      pos_y = '0;
    end else if (sum_y > $signed({2'b00, max_y})) begin
      pos_y = max_y;
    end else begin
      pos_y = sum_y[POS_Y_W-1:0];
    end
  end

  assign left_bit = sample.button_byte[0];
  assign wheel    = sample.button_byte[CNT_W-1 -: WHEEL_W];
  assign wdiff    = wheel - state.prev_wheel;

  assign col_full = pos_x >> X_SHIFT;
  assign row_full = pos_y >> Y_SHIFT;

  always_comb begin
    state_nxt.prev_x     = sample.counter_x;
    state_nxt.prev_y     = sample.counter_y;
    state_nxt.prev_left  = left_bit;
    state_nxt.prev_wheel = wheel;
    state_nxt.pos_x      = pos_x;
    state_nxt.pos_y      = pos_y;
    state_nxt.seen       = 1'b1;

    result.cell_col     = col_full[COL_W-1:0];
    result.cell_row     = row_full[ROW_W-1:0];
    result.left_click   = state.seen & state.prev_left & ~left_bit;
    result.left_held    = ~left_bit;
    // equal nibbles give a zero difference, so no separate compare
    result.wheel_change = state.seen ? {wdiff, {(WCHG_W-WHEEL_W){1'b0}}} : '0;
    result.moved        = state.seen & ((dx != '0) | (dy != '0));
  end

endmodule

// ===== tb/mouse_counter_to_cell_tracker_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mouse_counter_to_cell_tracker_test
// Self-checking bench for the mouse counter to cell tracker. Poll samples go
// in through the input stream and an in-bench cursor tracker predicts each
// result word. Directed tests cover the first sample, counter wrap at
// +127/-128, press edges, wheel steps and the screen clamps. Random phases
// follow, each under its own screen size. The sender works in bursts with
// gaps and the receiver stalls on a pattern of its own.
// ---------------------------------------------------------------------------
module mouse_counter_to_cell_tracker_test;
  import mctr_pkg::*;

  typedef struct {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              click;
    logic              held;
    logic [WCHG_W-1:0] wheel;
    logic              moved;
  } cell_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  mouse_counter_to_cell_tracker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Tracker state as the block should hold it
  logic [COLS_W-1:0]  scr_cols = COLS_W'(COLS_RESET);
  logic [ROWS_W-1:0]  scr_rows = ROWS_W'(ROWS_RESET);
  logic [CNT_W-1:0]   last_x = '0;
  logic [CNT_W-1:0]   last_y = '0;
  logic               last_left = 1'b1;
  logic [WHEEL_W-1:0] last_wheel = '0;
  int                 cur_x = (COLS_RESET / 2) * X_SCALE;
  int                 cur_y = (ROWS_RESET / 2) * Y_SCALE;
  bit                 seen = 1'b0;

  cell_report_t pending_reports[$];
  int mismatch_count = 0;
  int reports_checked = 0;
  int samples_sent = 0;
  int screens_used = 0;
  int burst_left = 0;

  function automatic int clamp_range(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic cell_report_t track_sample(input logic [CNT_W-1:0] cx,
                                                input logic [CNT_W-1:0] cy,
                                                input logic [CNT_W-1:0] bb);
    int cols;
    int rws;
    int dx;
    int dy;
    logic signed [CNT_W-1:0] d8;
    logic [WHEEL_W-1:0] wh;
    cell_report_t r;
    wh = bb[7:4];
    cols = clamp_range(scr_cols, 1, COLS_MAX);
    rws = clamp_range(scr_rows, 1, ROWS_MAX);
    r.click = 1'b0;
    r.wheel = '0;
    r.moved = 1'b0;
    if (!seen) begin
      // first sample just latches the counters and centres the cursor
      cur_x = (cols / 2) * X_SCALE;
      cur_y = (rws / 2) * Y_SCALE;
      seen = 1'b1;
    end else begin
      d8 = cx - last_x;
      dx = d8;
      d8 = last_y - cy;  // screen Y grows opposite to the counter
      dy = d8;
      if (dx != 0 || dy != 0) begin
        cur_x += dx;
        cur_y += dy;
        r.moved = 1'b1;
      end
      r.click = last_left & ~bb[0];
      if (wh != last_wheel) r.wheel = {4'(wh - last_wheel), 4'b0000};
    end
    // clamp to the current screen on every sample
    cur_x = clamp_range(cur_x, 0, (cols - 1) * X_SCALE);
    cur_y = clamp_range(cur_y, 0, (rws - 1) * Y_SCALE);
    last_x = cx;
    last_y = cy;
    last_left = bb[0];
    last_wheel = wh;
    r.col = COL_W'(cur_x / X_SCALE);
    r.row = ROW_W'(cur_y / Y_SCALE);
    r.held = ~bb[0];
    return r;
  endfunction

  // Receiver stall pattern: a new mode and mask are picked each time the tick counter wraps
  logic [5:0]  stall_tick = '0;
  logic [1:0]  stall_mode = '0;
  logic [15:0] stall_mask = '1;

  always @(posedge clk) begin
    if (stall_tick == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_mask <= 16'($urandom);
    end
    stall_tick <= stall_tick + 1'b1;
    case (stall_mode)
      2'd0: begin
        out_tready <= 1'b1;
      end
      2'd1: begin
        out_tready <= stall_mask[stall_tick[3:0]];
      end
      2'd2: begin
        out_tready <= stall_mask[stall_tick[3:0]] & ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_tready <= ($urandom_range(0, 1) == 1);
      end
    endcase
  end

  always @(posedge clk) begin : report_check
    cell_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result word %h with no sample pending", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (out_tdata[6:0] !== want.col) begin
          $error("cell_col: expected %0d, got %0d", want.col, out_tdata[6:0]);
          mismatch_count++;
        end
        if (out_tdata[12:7] !== want.row) begin
          $error("cell_row: expected %0d, got %0d", want.row, out_tdata[12:7]);
          mismatch_count++;
        end
        if (out_tdata[13] !== want.click) begin
          $error("left_click: expected %0b, got %0b", want.click, out_tdata[13]);
          mismatch_count++;
        end
        if (out_tdata[14] !== want.held) begin
          $error("left_held: expected %0b, got %0b", want.held, out_tdata[14]);
          mismatch_count++;
        end
        if (out_tdata[22:15] !== want.wheel) begin
          $error("wheel_change: expected %0d, got %0d",
                 $signed(want.wheel), $signed(out_tdata[22:15]));
          mismatch_count++;
        end
        if (out_tdata[23] !== want.moved) begin
          $error("moved: expected %0b, got %0b", want.moved, out_tdata[23]);
          mismatch_count++;
        end
      end
    end
  end

  // Send one poll sample; valid stays high between words of a burst.
  task automatic send_sample(input logic [CNT_W-1:0] cx, input logic [CNT_W-1:0] cy,
                             input logic [CNT_W-1:0] bb);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tdata <= {bb, cy, cx};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_reports.push_back(track_sample(cx, cy, bb));
    samples_sent++;
    burst_left--;
  endtask

  // Move by a screen-space delta (positive dy = down the screen)
  task automatic send_move(input int dx, input int dy, input logic [CNT_W-1:0] bb);
    send_sample(8'(int'(last_x) + dx), 8'(int'(last_y) - dy), bb);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_screen(input logic [COLS_W-1:0] cols,
                              input logic [CFG_DATA_W-1:0] rws);
    cfg_we <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_wdata <= cols;
    @(posedge clk);
    scr_cols = cols;
    cfg_index <= REG_ROWS;
    cfg_wdata <= rws;
    @(posedge clk);
    scr_rows = rws[ROWS_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
    screens_used++;
  endtask

  task automatic test_first_sample();
    // pressed on the very first sample: held, but no click and no wheel step
    send_sample(8'h37, 8'hc2, 8'hae);
    send_move(0, 0, 8'hae);
  endtask

  task automatic test_counter_wrap();
    send_move(127, -127, 8'hae);
    send_move(-128, 127, 8'hae);
    send_move(-128, -128, 8'hae);
    send_move(1, -1, 8'hae);
    send_move(0, 0, 8'h51);
    send_sample(8'hff, 8'h00, 8'h51);
  endtask

  task automatic test_buttons_wheel();
    send_sample(last_x, last_y, 8'h00);  // press + wheel to 0
    send_sample(last_x, last_y, 8'h00);
    send_sample(last_x, last_y, 8'h01);
    send_sample(last_x, last_y, 8'hf0);  // press, wheel 0 -> F
    send_sample(last_x, last_y, 8'h0f);  // wheel F -> 0, upper bits toggle
    send_sample(last_x, last_y, 8'h8e);  // wheel 0 -> 8: -128
    send_sample(last_x, last_y, 8'h71);
  endtask

  task automatic test_screen_clamp();
    int i;
    wait_idle();
    write_screen(8'd128, 8'd64);
    for (i = 0; i < 5; i++) send_move(127, 127, 8'h01);
    wait_idle();
    // shrink under a cursor in the far corner: re-clamped without motion
    write_screen(8'd1, 8'd1);
    send_move(0, 0, 8'h01);
    wait_idle();
    write_screen(8'd0, 8'd0);
    send_move(5, 5, 8'h01);
    wait_idle();
    write_screen(8'd255, 8'd127);
    send_move(127, 127, 8'h01);
    for (i = 0; i < 5; i++) send_move(-128, -128, 8'h01);
  endtask

  task automatic run_random_phase(input int n);
    int i;
    int dx;
    int dy;
    int drift_x;
    int drift_y;
    logic lb;
    logic [WHEEL_W-1:0] nib;
    drift_x = $urandom_range(0, 8);
    drift_x -= 4;
    drift_y = $urandom_range(0, 8);
    drift_y -= 4;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        dx = $urandom_range(0, 8);
        dx += drift_x - 4;
        dy = $urandom_range(0, 8);
        dy += drift_y - 4;
        if ($urandom_range(0, 15) == 0) begin
          dx = $urandom_range(0, 255);
          dx -= 128;
        end
        if ($urandom_range(0, 15) == 0) begin
          dy = $urandom_range(0, 255);
          dy -= 128;
        end
        if ($urandom_range(0, 5) == 0) begin
          dx = 0;
          dy = 0;
        end
        lb = ($urandom_range(0, 3) == 0) ? ~last_left : last_left;
        nib = last_wheel;
        case ($urandom_range(0, 7))
          0: nib = last_wheel + 1'b1;
          1: nib = last_wheel - 1'b1;
          2: nib = 4'($urandom);
          default: nib = last_wheel;
        endcase
        send_move(dx, dy, {nib, 3'($urandom), lb});
      end else begin
        send_sample(8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic test_random_screens();
    int p;
    logic [COLS_W-1:0] cols;
    logic [CFG_DATA_W-1:0] rws;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin cols = 8'd80;  rws = 8'd25;  end
        1: begin cols = 8'd0;   rws = 8'd0;   end
        2: begin cols = 8'd255; rws = 8'd255; end
        3: begin cols = 8'd128; rws = 8'd64;  end
        4: begin cols = 8'd1;   rws = 8'd64;  end
        5: begin cols = 8'd128; rws = 8'd1;   end
        default: begin
          cols = 8'($urandom);
          rws = 8'($urandom);
        end
      endcase
      wait_idle();
      write_screen(cols, rws);
      run_random_phase(200);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_first_sample();
    test_counter_wrap();
    test_buttons_wheel();
    test_screen_clamp();
    test_random_screens();
    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d results never arrived", pending_reports.size());
      mismatch_count++;
    end
    $display("Sent %0d poll samples under %0d screen sizes, checked %0d result words",
             samples_sent, screens_used, reports_checked);
    $display("(clamps, counter wrap, press edges, wheel steps, stalls and gaps)");
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
